>>> src/nntb_pkg.sv
// Shared constants and types of the nearest-neighbor tour builder.
`timescale 1ns / 1ps

package nntb_pkg;

  // Fixed field widths of the ports
  localparam int unsigned CITY_W = 6;
  localparam int unsigned CFG_W  = 7;
  localparam int unsigned DIN_W  = 24;
  localparam int unsigned COST_W = 30;

  // Parameter defaults
  localparam int unsigned MAX_CITIES_DEF = 64;
  localparam int unsigned DIST_BITS_DEF  = 24;

  // Smallest usable city count and reset value of the register
  localparam logic [CFG_W-1:0] MIN_COUNT   = 7'd3;
  localparam logic [CFG_W-1:0] COUNT_RESET = 7'd64;

  // Start value of the running minimum; any stored distance is below it
  localparam logic [COST_W-1:0] NOT_FOUND = 30'd1000000000;
  // Saturation value of the closed tour cost
  localparam logic [COST_W-1:0] COST_MAX  = 30'd1073741823;

  // Control of the shared compare unit
  typedef struct packed {
    logic clr;  // restart the minimum search
    logic cmp;  // compare the candidate on this cycle
  } min_ctl_t;

endpackage

>>> src/nntb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module nntb_ram #(
  parameter int unsigned WIDTH  = 24,
  parameter int unsigned DEPTH  = 2016,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/nntb_argmin.sv
// Shared compare unit: running minimum distance and its city, lowest index first.
`timescale 1ns / 1ps

module nntb_argmin
  import nntb_pkg::*;
#(
  parameter int unsigned IDX_W = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  min_ctl_t          ctl_i,
  input  logic [IDX_W-1:0]  cand_idx_i,
  input  logic [COST_W-1:0] cand_dist_i,
  output logic [IDX_W-1:0]  best_idx_o,
  output logic [COST_W-1:0] best_dist_o
);

  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic [COST_W-1:0] best_dist_q, best_dist_d;

  // Take a candidate only when strictly smaller, so earlier cities win ties
  always_comb begin
    best_idx_d  = best_idx_q;
    best_dist_d = best_dist_q;
    if (ctl_i.clr) begin
      best_idx_d  = '0;
      best_dist_d = NOT_FOUND;
    end else if (ctl_i.cmp && (cand_dist_i < best_dist_q)) begin
      best_idx_d  = cand_idx_i;
      best_dist_d = cand_dist_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_idx_q  <= '0;
      best_dist_q <= NOT_FOUND;
    end else begin
      best_idx_q  <= best_idx_d;
      best_dist_q <= best_dist_d;
    end
  end

  assign best_idx_o  = best_idx_q;
  assign best_dist_o = best_dist_q;

endmodule

>>> src/nearest_neighbor_tour_builder.sv
// Top level: greedy nearest-neighbor tour builder over a triangular distance RAM.
// A load transaction is taken whenever the block is idle. A build with n cities stalls the input
// until its final result has been issued, including any wait on out_stall_i: each of the n-1 tour
// steps emits a city, scans all n cities one RAM read a cycle, then drains and steps; the return
// edge is read and added, and then the final result is emitted.
// Reset clears control state and sets the city count to 64; the distance RAM stays undefined.
`timescale 1ns / 1ps

module nearest_neighbor_tour_builder
  import nntb_pkg::*;
#(
  parameter int unsigned MAX_CITIES = MAX_CITIES_DEF,
  parameter int unsigned DIST_BITS  = DIST_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_W-1:0]  cfg_city_count_i,
  // input items
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              kind_i,
  input  logic [CITY_W-1:0] row_city_i,
  input  logic [CITY_W-1:0] col_city_i,
  input  logic [DIN_W-1:0]  distance_i,
  input  logic [CITY_W-1:0] start_city_i,
  // result items
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CITY_W-1:0] city_o,
  output logic [CITY_W-1:0] position_o,
  output logic              last_o,
  output logic [COST_W-1:0] tour_cost_o
);

  localparam int unsigned DEPTH  = (MAX_CITIES * (MAX_CITIES - 1)) / 2;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CIDX_W = $clog2(MAX_CITIES);
  localparam int unsigned CNT_W  = CIDX_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_SCAN,
    ST_DRAIN,
    ST_STEP,
    ST_RET_RD,
    ST_RET_ADD,
    ST_LAST
  } state_e;

  // Slot of a city pair in the triangular store: hi*(hi-1)/2 + lo
  function automatic logic [11:0] pair_slot(input logic [CITY_W-1:0] a,
                                            input logic [CITY_W-1:0] b);
    logic [CITY_W-1:0] hi;
    logic [CITY_W-1:0] lo;
    logic [11:0]       prod;
    hi   = (a > b) ? a : b;
    lo   = (a > b) ? b : a;
    prod = {6'd0, hi} * {6'd0, hi - 6'd1};
    return (prod >> 1) + {6'd0, lo};
  endfunction

  // Add a distance to the cost, clamping at the largest cost
  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
  endfunction

  state_e              state_q, state_d;
  logic [CFG_W-1:0]    cfg_count_q, cfg_count_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [CIDX_W-1:0]   here_q, here_d;
  logic [CIDX_W-1:0]   start_q, start_d;
  logic [CIDX_W-1:0]   j_q, j_d;
  logic [CIDX_W-1:0]   pos_q, pos_d;
  logic [MAX_CITIES-1:0] visited_q, visited_d;
  logic [COST_W-1:0]   cost_q, cost_d;
  logic                cand_vld_q, cand_vld_d;
  logic [CIDX_W-1:0]   cand_idx_q, cand_idx_d;
  logic                out_valid_q, out_valid_d;
  logic [CITY_W-1:0]   out_city_q, out_city_d;
  logic [CITY_W-1:0]   out_pos_q, out_pos_d;
  logic                out_last_q, out_last_d;
  logic [COST_W-1:0]   out_cost_q, out_cost_d;

  logic                in_accept;
  logic                out_free;
  logic [CFG_W-1:0]    n_eff;
  logic                load_ok;
  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [DIST_BITS-1:0] wdata;
  logic [CIDX_W-1:0]   other;
  logic [ADDR_W-1:0]   raddr;
  logic [DIST_BITS-1:0] rdata;
  logic [11:0]         wslot;
  logic [11:0]         rslot;
  logic                j_last;
  logic                pos_last;
  min_ctl_t            min_ctl;
  logic [CIDX_W-1:0]   best_idx;
  logic [COST_W-1:0]   best_dist;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Clamp the configured city count into the usable range
  always_comb begin
    if (cfg_count_q < MIN_COUNT) begin
      n_eff = MIN_COUNT;
    end else if (cfg_count_q > CFG_W'(MAX_CITIES)) begin
      n_eff = CFG_W'(MAX_CITIES);
    end else begin
      n_eff = cfg_count_q;
    end
  end

  // Write path for distance loads
  assign load_ok = (row_city_i != col_city_i)
                && ({1'b0, row_city_i} < CFG_W'(MAX_CITIES))
                && ({1'b0, col_city_i} < CFG_W'(MAX_CITIES));
  assign we      = in_accept && !kind_i && load_ok;
  assign wslot   = pair_slot(row_city_i, col_city_i);
  assign waddr   = wslot[ADDR_W-1:0];
  assign wdata   = DIST_BITS'(distance_i);

  // Read path: scan candidate, or the start city for the return edge
  assign other = (state_q == ST_RET_RD) ? start_q : j_q;
  assign rslot = pair_slot(CITY_W'(here_q), CITY_W'(other));
  assign raddr = rslot[ADDR_W-1:0];

  assign j_last   = ({1'b0, j_q} == (n_q - 1'b1));
  assign pos_last = ({1'b0, pos_q} == (n_q - 1'b1));

  assign min_ctl.clr = (state_q == ST_EMIT) && out_free;
  assign min_ctl.cmp = cand_vld_q;

  nntb_ram #(
    .WIDTH  (DIST_BITS),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  nntb_argmin #(
    .IDX_W (CIDX_W)
  ) u_argmin (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (min_ctl),
    .cand_idx_i  (cand_idx_q),
    .cand_dist_i (COST_W'(rdata)),
    .best_idx_o  (best_idx),
    .best_dist_o (best_dist)
  );

  // Sequencer: next state and registered outputs
  always_comb begin
    state_d     = state_q;
    cfg_count_d = cfg_count_q;
    n_d         = n_q;
    here_d      = here_q;
    start_d     = start_q;
    j_d         = j_q;
    pos_d       = pos_q;
    visited_d   = visited_q;
    cost_d      = cost_q;
    cand_vld_d  = 1'b0;
    cand_idx_d  = j_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_city_d  = out_city_q;
    out_pos_d   = out_pos_q;
    out_last_d  = out_last_q;
    out_cost_d  = out_cost_q;

    if (cfg_valid_i && cfg_ready_o) begin
      cfg_count_d = cfg_city_count_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        // start a build if the start city is in range
        if (in_accept && kind_i && ({1'b0, start_city_i} < n_eff)) begin
          n_d       = CNT_W'(n_eff);
          here_d    = start_city_i[CIDX_W-1:0];
          start_d   = start_city_i[CIDX_W-1:0];
          visited_d = '0;
          visited_d[start_city_i[CIDX_W-1:0]] = 1'b1;
          cost_d    = '0;
          pos_d     = '0;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // emit the current city, then scan for the next one
        if (out_free) begin
          out_valid_d = 1'b1;
          out_city_d  = CITY_W'(here_q);
          out_pos_d   = CITY_W'(pos_q);
          out_last_d  = 1'b0;
          out_cost_d  = '0;
          pos_d       = pos_q + 1'b1;
          j_d         = '0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue one read a cycle; the compare follows in the next cycle
        cand_vld_d = !visited_q[j_q];
        cand_idx_d = j_q;
        if (j_last) begin
          state_d = ST_DRAIN;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_STEP;
      end
      ST_STEP: begin
        // move to the nearest unvisited city
        cost_d              = sat_add(cost_q, best_dist);
        here_d              = best_idx;
        visited_d[best_idx] = 1'b1;
        state_d             = pos_last ? ST_RET_RD : ST_EMIT;
      end
      ST_RET_RD: begin
        state_d = ST_RET_ADD;
      end
      ST_RET_ADD: begin
        // close the tour with the edge back to the start
        cost_d  = sat_add(cost_q, COST_W'(rdata));
        state_d = ST_LAST;
      end
      ST_LAST: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_city_d  = CITY_W'(here_q);
          out_pos_d   = CITY_W'(pos_q);
          out_last_d  = 1'b1;
          out_cost_d  = cost_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_count_q <= COUNT_RESET;
      n_q         <= '0;
      here_q      <= '0;
      start_q     <= '0;
      j_q         <= '0;
      pos_q       <= '0;
      visited_q   <= '0;
      cost_q      <= '0;
      cand_vld_q  <= 1'b0;
      cand_idx_q  <= '0;
      out_valid_q <= 1'b0;
      out_city_q  <= '0;
      out_pos_q   <= '0;
      out_last_q  <= 1'b0;
      out_cost_q  <= '0;
    end else begin
      state_q     <= state_d;
      cfg_count_q <= cfg_count_d;
      n_q         <= n_d;
      here_q      <= here_d;
      start_q     <= start_d;
      j_q         <= j_d;
      pos_q       <= pos_d;
      visited_q   <= visited_d;
      cost_q      <= cost_d;
      cand_vld_q  <= cand_vld_d;
      cand_idx_q  <= cand_idx_d;
      out_valid_q <= out_valid_d;
      out_city_q  <= out_city_d;
      out_pos_q   <= out_pos_d;
      out_last_q  <= out_last_d;
      out_cost_q  <= out_cost_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign city_o      = out_city_q;
  assign position_o  = out_pos_q;
  assign last_o      = out_last_q;
  assign tour_cost_o = out_cost_q;

  // A valid build start always leaves idle
  a_build_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && kind_i && ({1'b0, start_city_i} < n_eff)) |=> in_stall_o)
    else $error("accepted build did not start");

  // The chosen next city was found and is still unvisited
  a_step_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (best_dist != NOT_FOUND) && !visited_q[best_idx])
    else $error("step picked no unvisited city");

  // The scan never runs past the active city count
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ({1'b0, j_q} < n_q))
    else $error("scan index out of range");

  // Visited marks match the count of tour positions emitted so far
  a_visited_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ($countones(visited_q) == pos_q))
    else $error("visited marks out of step with tour position");

  // Only the final result carries a cost
  a_cost_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (tour_cost_o == '0))
    else $error("cost on a non-final result");

endmodule

>>> tb/nearest_neighbor_tour_builder_tb.sv
// Self-checking testbench of the nearest-neighbor tour builder: loads, tour builds, city count.
`timescale 1ns / 1ps

module nearest_neighbor_tour_builder_tb;
  import nntb_pkg::*;

  localparam int unsigned CITIES        = MAX_CITIES_DEF;
  localparam int unsigned FILL_CITIES   = 8;
  localparam logic        KIND_LOAD     = 1'b0;
  localparam logic        KIND_BUILD    = 1'b1;
  localparam int unsigned IDLE_PCT      = 36;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned TAIL_CYCLES   = 200;
  localparam int unsigned QUIET_LIMIT   = 20000;

  typedef struct packed {
    logic              kind;
    logic [CITY_W-1:0] row_city;
    logic [CITY_W-1:0] col_city;
    logic [DIN_W-1:0]  distance;
    logic [CITY_W-1:0] start_city;
  } tour_item_t;

  typedef struct packed {
    logic [CITY_W-1:0] city;
    logic [CITY_W-1:0] position;
    logic              last;
    logic [COST_W-1:0] cost;
  } tour_step_t;

  logic              clk_i;
  logic              rst_ni           = 1'b0;
  logic              cfg_valid_i      = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_city_count_i = '0;
  logic              in_valid_i       = 1'b0;
  logic              in_stall_o;
  logic              kind_i           = KIND_LOAD;
  logic [CITY_W-1:0] row_city_i       = '0;
  logic [CITY_W-1:0] col_city_i       = '0;
  logic [DIN_W-1:0]  distance_i       = '0;
  logic [CITY_W-1:0] start_city_i     = '0;
  logic              out_valid_o;
  logic              out_stall_i      = 1'b0;
  logic [CITY_W-1:0] city_o;
  logic [CITY_W-1:0] position_o;
  logic              last_o;
  logic [COST_W-1:0] tour_cost_o;

  // Predicted state of the block
  logic [DIN_W-1:0]  dist_tab [CITIES][CITIES];
  bit                visited_mark [CITIES];
  logic [CITY_W-1:0] tour_end_city;
  logic [COST_W-1:0] tour_cost_sum;
  logic [CFG_W-1:0]  city_count_reg = COUNT_RESET;

  tour_step_t  tour_steps_q[$];
  tour_step_t  want_step;
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  bit          gaps_on      = 1'b0;

  nearest_neighbor_tour_builder u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_city_count_i (cfg_city_count_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .row_city_i       (row_city_i),
    .col_city_i       (col_city_i),
    .distance_i       (distance_i),
    .start_city_i     (start_city_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .city_o           (city_o),
    .position_o       (position_o),
    .last_o           (last_o),
    .tour_cost_o      (tour_cost_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Clamp the city count register to the usable range
  function automatic int unsigned active_cities();
    if (city_count_reg < MIN_COUNT) return MIN_COUNT;
    if (city_count_reg > CITIES) return CITIES;
    return city_count_reg;
  endfunction

  // Walk the greedy tour and queue one expected result per city
  function automatic void predict_tour(input logic [CITY_W-1:0] start);
    int unsigned       n;
    int unsigned       here;
    int unsigned       best;
    logic [COST_W-1:0] best_d;
    longint unsigned   total;
    tour_step_t        s;
    n = active_cities();
    if (start >= n) return;
    foreach (visited_mark[j]) visited_mark[j] = 1'b0;
    here = start;
    visited_mark[here] = 1'b1;
    total = 0;
    s = '{city: start, position: '0, last: 1'b0, cost: '0};
    for (int unsigned step = 1; step < n; step++) begin
      tour_steps_q.push_back(s);
      best   = here;
      best_d = NOT_FOUND;
      // lowest index wins ties: only a strictly smaller distance replaces
      for (int unsigned j = 0; j < n; j++) begin
        if (!visited_mark[j] && dist_tab[here][j] < best_d) begin
          best_d = dist_tab[here][j];
          best   = j;
        end
      end
      total += dist_tab[here][best];
      here = best;
      visited_mark[here] = 1'b1;
      s = '{city: CITY_W'(here), position: CITY_W'(step), last: 1'b0, cost: '0};
    end
    // close the tour and saturate
    total += dist_tab[here][start];
    if (total > COST_MAX) total = COST_MAX;
    tour_end_city = CITY_W'(here);
    tour_cost_sum = COST_W'(total);
    s.last = 1'b1;
    s.cost = tour_cost_sum;
    tour_steps_q.push_back(s);
  endfunction

  // Update the predicted state with one accepted transaction
  function automatic void apply_item(input tour_item_t it);
    if (it.kind == KIND_BUILD) begin
      predict_tour(it.start_city);
    end else if (it.row_city != it.col_city) begin
      dist_tab[it.row_city][it.col_city] = it.distance;
      dist_tab[it.col_city][it.row_city] = it.distance;
    end
  endfunction

  // Favor tiny values so that ties show up, with the extremes mixed in
  function automatic logic [DIN_W-1:0] pick_distance();
    case ($urandom_range(7))
      0, 1, 2: return DIN_W'($urandom_range(3));
      3:       return '1;
      default: return DIN_W'($urandom);
    endcase
  endfunction

  function automatic tour_item_t random_item(input int unsigned n);
    tour_item_t  it;
    int unsigned r;
    it.kind       = KIND_LOAD;
    it.row_city   = CITY_W'($urandom_range(n - 1));
    it.col_city   = CITY_W'((it.row_city + 1 + $urandom_range(n - 2)) % n);
    it.distance   = pick_distance();
    it.start_city = CITY_W'($urandom);
    r = $urandom_range(99);
    if (r >= 50 && r < 58) begin
      // pair anywhere in the store, diagonal possible
      it.row_city = CITY_W'($urandom);
      it.col_city = CITY_W'($urandom);
    end else if (r >= 58 && r < 62) begin
      it.col_city = it.row_city;
    end else if (r >= 62 && (r < 90 || n >= CITIES)) begin
      it.kind       = KIND_BUILD;
      it.start_city = CITY_W'($urandom_range(n - 1));
      it.row_city   = CITY_W'($urandom);
      it.col_city   = CITY_W'($urandom);
    end else if (r >= 90) begin
      // start outside the active cities: dropped by the block
      it.kind       = KIND_BUILD;
      it.start_city = CITY_W'($urandom_range(CITIES - 1, n));
    end
    return it;
  endfunction

  // Present one transaction and hold it until accepted
  task automatic send_item(input tour_item_t it);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= it.kind;
    row_city_i   <= it.row_city;
    col_city_i   <= it.col_city;
    distance_i   <= it.distance;
    start_city_i <= it.start_city;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_item(it);
  endtask

  task automatic send_load(input int unsigned row, input int unsigned col,
                           input logic [DIN_W-1:0] value);
    send_item('{kind: KIND_LOAD, row_city: CITY_W'(row), col_city: CITY_W'(col),
                distance: value, start_city: CITY_W'($urandom)});
  endtask

  task automatic send_build(input int unsigned start);
    send_item('{kind: KIND_BUILD, row_city: CITY_W'($urandom), col_city: CITY_W'($urandom),
                distance: DIN_W'($urandom), start_city: CITY_W'(start)});
  endtask

  // Drop valid and wait until every expected result has come
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    while (tour_steps_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_city_count(input logic [CFG_W-1:0] value);
    hold_until_drained();
    cfg_valid_i      <= 1'b1;
    cfg_city_count_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i    <= 1'b0;
    city_count_reg = value;
  endtask

  // Load every pair among the cities that builds use, each pair with its cities in random order
  task automatic test_store_fill();
    for (int unsigned hi = 1; hi < FILL_CITIES; hi++) begin
      for (int unsigned lo = 0; lo < hi; lo++) begin
        if ($urandom_range(1) != 0) send_load(hi, lo, pick_distance());
        else send_load(lo, hi, pick_distance());
      end
    end
  endtask

  // Builds over every loaded city
  task automatic test_full_count_builds();
    write_city_count(CFG_W'(FILL_CITIES));
    send_build(0);
    send_build(FILL_CITIES - 1);
    hold_until_drained();
  endtask

  task automatic test_min_count();
    write_city_count(MIN_COUNT);
    send_build(0);
    send_build(1);
    send_build(2);
    send_build(3);
    send_build(CITIES - 1);
    write_city_count(7'd0);
    send_build(2);
    write_city_count(7'd2);
    send_build(1);
  endtask

  task automatic test_ties();
    write_city_count(7'd4);
    for (int unsigned hi = 1; hi < 4; hi++) begin
      for (int unsigned lo = 0; lo < hi; lo++) send_load(hi, lo, DIN_W'(5));
    end
    send_build(0);
    send_load(2, 1, '0);
    send_build(3);
    write_city_count(MIN_COUNT);
    send_load(0, 1, '1);
    send_load(2, 0, '1);
    send_load(1, 2, '1);
    send_build(1);
  endtask

  // Loads onto the diagonal must leave the store alone
  task automatic test_diagonal_load();
    send_load(0, 0, '0);
    send_load(CITIES - 1, CITIES - 1, '1);
    send_load(2, 2, DIN_W'(7));
    send_build(0);
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] count, input int unsigned items);
    write_city_count(count);
    repeat (items) begin
      send_item(random_item(count));
      if ($urandom_range(14) == 0) hold_until_drained();
    end
  endtask

  task automatic test_random();
    random_phase(7'd5, 10);
    random_phase(7'd3, 10);
    random_phase(7'd8, 12);
    random_phase(7'd7, 12);
    random_phase(7'd6, 12);
  endtask

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // Check each accepted result against the oldest expectation, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tour_steps_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result: expected none, got city %0d position %0d",
                 $time, city_o, position_o);
      end else begin
        want_step = tour_steps_q.pop_front();
        check_field("city", want_step.city, city_o);
        check_field("position", want_step.position, position_o);
        check_field("last", want_step.last, last_o);
        check_field("tour_cost", want_step.cost, tour_cost_o);
      end
    end
    out_stall_i <= gaps_on && ($urandom_range(99) < IDLE_PCT);
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, tour_steps_q.size());
      $display("nearest_neighbor_tour_builder test failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // no idling while the store fills and the first tours come out
    test_store_fill();
    test_full_count_builds();
    gaps_on = 1'b1;
    test_min_count();
    test_ties();
    test_diagonal_load();
    test_random();
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("nearest_neighbor_tour_builder test passed");
    end else begin
      $display("nearest_neighbor_tour_builder test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/nntb_pkg.sv
src/nntb_ram.sv
src/nntb_argmin.sv
src/nearest_neighbor_tour_builder.sv
tb/nearest_neighbor_tour_builder_tb.sv
